>>> sv/bfm_pkg.sv
package bfm_pkg;

	// frame size limits and line store geometry
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	// wide enough for a clamped size plus the border offset
	localparam int DIM_W      = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

	// register map
	localparam int CFG_W      = 12;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

	// filter geometry
	localparam int MIN_SIZE   = 5;
	localparam int EDGE       = 2;
	localparam int GROUP      = 16;
	localparam int TAPS       = 5;

	// payload widths
	localparam int PIX_W      = 8;
	localparam int POS_W      = 11;
	localparam int WORD_W     = (TAPS - 1) * PIX_W;
	localparam int CS_W       = 11;   // one column of five pixels, at most 1275
	localparam int SUM_W      = 13;   // whole window, at most 6375

	// divide by 25 as multiply by reciprocal; exact for sums up to 6375
	localparam int DIV_SH     = 17;
	localparam int DIV_K      = 5243;
	localparam int PROD_W     = SUM_W + 13;

endpackage

>>> sv/bfm_div25.sv
module bfm_div25
	import bfm_pkg::*;
(
	input  logic [SUM_W-1:0] sum,
	output logic [PIX_W-1:0] quotient
);

	logic [PROD_W-1:0] prod;

	// floor(sum / 25) = (sum * ceil(2^17 / 25)) >> 17 over the full sum range
	assign prod     = PROD_W'(sum) * PROD_W'(DIV_K);
	assign quotient = prod[DIV_SH +: PIX_W];

endmodule

>>> sv/box_filter_5x5_mean_core.sv
// 5x5 mean filter, one pixel beat per clock in raster order while pixel_ready is high.
// a result beat passes s1, s2, s3 and the output register after the beat completing its window.
// throughput: one pixel per cycle while not stalled; the line store is read at accept
// and written when the beat leaves s1, so back-to-back beats never wait on the memory port.
// reset: counters, window column sums and all stage valids clear at once; registers
// return to 640x480; the line store is not cleared and holds garbage until written.
module box_filter_5x5_mean_core
	import bfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,

	// pixel stream
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              start_of_frame,

	// filtered stream
	output logic              result_valid,
	input  logic              result_ready,
	output logic [PIX_W-1:0]  mean_value,
	output logic [POS_W-1:0]  out_col,
	output logic [POS_W-1:0]  out_row,
	output logic              last_of_frame
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// effective frame geometry
	// sizes are clamped to MIN_SIZE..MAX; filtered columns are trimmed to a
	// whole number of 16-wide groups after the two-pixel border on each side
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] fw_raw, fh_raw;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [DIM_W-1:0] grp_cols;

	assign fw_raw = DIM_W'(frame_width_q);
	assign fh_raw = DIM_W'(frame_height_q);

	always_comb begin
		if (fw_raw < DIM_W'(MIN_SIZE))
			w_eff = DIM_W'(MIN_SIZE);
		else if (fw_raw > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = fw_raw;

		if (fh_raw < DIM_W'(MIN_SIZE))
			h_eff = DIM_W'(MIN_SIZE);
		else if (fh_raw > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = fh_raw;
	end

	assign grp_cols = ((w_eff - DIM_W'(2 * EDGE)) >> $clog2(GROUP)) << $clog2(GROUP);

	// ------------------------------------------------------------------
	// stage handshake
	// s1: line store word comes back, window shifts, store is written
	// s2: window sum, s3: quotient, then the output register
	// only beats that produce a result travel past s1
	// ------------------------------------------------------------------
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic emit_s1;
	logic rdy_out, rdy3, rdy2, rdy1;
	logic s1_go, accept;

	assign rdy_out     = !out_valid_q || result_ready;
	assign rdy3        = !v3_s3 || rdy_out;
	assign rdy2        = !v2_s2 || rdy3;
	assign s1_go       = v1_s1 && (!emit_s1 || rdy2);
	assign rdy1        = !v1_s1 || s1_go;
	assign pixel_ready = rdy1;
	assign accept      = pixel_valid && rdy1;

	// ------------------------------------------------------------------
	// position counters, advanced at the accept edge
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [DIM_W-1:0] c_ext, r_ext;
	logic             col_wrap, row_wrap;
	logic             emit_cur, last_cur;

	assign col_cur  = start_of_frame ? '0 : col_q;
	assign row_cur  = start_of_frame ? '0 : row_q;
	assign c_ext    = DIM_W'(col_cur);
	assign r_ext    = DIM_W'(row_cur);
	assign col_wrap = (c_ext + DIM_W'(1)) >= w_eff;
	assign row_wrap = (r_ext + DIM_W'(1)) >= h_eff;

	// the newest pixel sits two rows and two columns past the window center
	assign emit_cur = (r_ext >= DIM_W'(2 * EDGE)) && (r_ext < h_eff) &&
			  (c_ext >= DIM_W'(2 * EDGE)) &&
			  (c_ext < grp_cols + DIM_W'(2 * EDGE));
	assign last_cur = (c_ext == grp_cols + DIM_W'(2 * EDGE - 1)) &&
			  (r_ext == h_eff - DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_cur + ROW_W'(1);
			end else begin
				col_q <= col_cur + COL_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// line store: four previous rows per column, oldest row in the low byte
	// read at accept, written when the beat leaves s1
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] line_mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_word_q;
	logic [WORD_W-1:0] wr_word_q;
	logic [WORD_W-1:0] stored;
	logic [WORD_W-1:0] new_word;
	logic [COL_W-1:0]  addr_s1;

	always_ff @(posedge clk) begin
		if (s1_go)
			line_mem[addr_s1] <= new_word;
		if (accept)
			rd_word_q <= line_mem[col_cur];
	end

	// s1 payload
	logic [PIX_W-1:0] pix_s1;
	logic [POS_W-1:0] ocol_s1, orow_s1;
	logic             last_s1;
	logic             fwd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_s1 <= 1'b0;
		else if (rdy1)
			v1_s1 <= pixel_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			addr_s1 <= col_cur;
			emit_s1 <= emit_cur;
			last_s1 <= last_cur;
			ocol_s1 <= POS_W'(c_ext - DIM_W'(EDGE));
			orow_s1 <= POS_W'(r_ext - DIM_W'(EDGE));
			// a repeated start of frame revisits the column being written now
			fwd_s1  <= s1_go && (addr_s1 == col_cur);
		end
		if (s1_go)
			wr_word_q <= new_word;
	end

	assign stored   = fwd_s1 ? wr_word_q : rd_word_q;
	assign new_word = {pix_s1, stored[WORD_W-1:PIX_W]};

	// ------------------------------------------------------------------
	// window kept as five column sums, oldest first
	// ------------------------------------------------------------------
	logic [CS_W-1:0]  col_sum_q [TAPS];
	logic [CS_W-1:0]  col_new;
	logic [SUM_W-1:0] win_sum;

	always_comb begin
		col_new = CS_W'(pix_s1);
		for (int i = 0; i < TAPS - 1; i++)
			col_new = col_new + CS_W'(stored[i*PIX_W +: PIX_W]);
		win_sum = SUM_W'(col_new);
		for (int i = 1; i < TAPS; i++)
			win_sum = win_sum + SUM_W'(col_sum_q[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				col_sum_q[i] <= '0;
		end else if (s1_go) begin
			for (int i = 0; i < TAPS - 1; i++)
				col_sum_q[i] <= col_sum_q[i+1];
			col_sum_q[TAPS-1] <= col_new;
		end
	end

	// ------------------------------------------------------------------
	// s2: window sum
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] sum_s2;
	logic [POS_W-1:0] ocol_s2, orow_s2;
	logic             last_s2;
	logic             load2;

	assign load2 = s1_go && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v2_s2 <= 1'b0;
		else if (rdy2)
			v2_s2 <= load2;
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			sum_s2  <= win_sum;
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3: divide by 25
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] quot;
	logic [PIX_W-1:0] mean_s3;
	logic [POS_W-1:0] ocol_s3, orow_s3;
	logic             last_s3;

	bfm_div25 u_div (
		.sum      (sum_s2),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v3_s3 <= 1'b0;
		else if (rdy3)
			v3_s3 <= v2_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			mean_s3 <= quot;
			ocol_s3 <= ocol_s2;
			orow_s3 <= orow_s2;
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] mean_q;
	logic [POS_W-1:0] ocol_q, orow_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rdy_out)
			out_valid_q <= v3_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v3_s3) begin
			mean_q <= mean_s3;
			ocol_q <= ocol_s3;
			orow_q <= orow_s3;
			last_q <= last_s3;
		end
	end

	assign result_valid  = out_valid_q;
	assign mean_value    = mean_q;
	assign out_col       = ocol_q;
	assign out_row       = orow_q;
	assign last_of_frame = last_q;

endmodule

>>> tb/box_filter_5x5_mean_core_tb.sv
module box_filter_5x5_mean_core_tb;
	import bfm_pkg::*;

	// register byte addresses, one 32-bit word per register
	localparam logic [ADDR_W-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

	// result beats trail their pixel beat through the pipeline registers; this settle time covers that
	localparam int SETTLE_CYCLES = 8;
	// longest legal quiet stretch is the hold-off plus a stall burst
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;
	// random frames run until at least this many pixels went out
	localparam int RANDOM_ITEMS  = 80;

	typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_WHITE} pix_mode_t;

	// one expected beat on the filtered stream
	typedef struct packed {
		logic [PIX_W-1:0] mean;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} mean_beat_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              pixel_valid;
	logic              pixel_ready;
	logic [PIX_W-1:0]  pixel;
	logic              start_of_frame;
	logic              result_valid;
	logic              result_ready;
	logic [PIX_W-1:0]  mean_value;
	logic [POS_W-1:0]  out_col;
	logic [POS_W-1:0]  out_row;
	logic              last_of_frame;

	// expected filtered beats, oldest first
	mean_beat_t pending_means[$];
	int         error_count = 0;
	int         quiet_cycles = 0;

	// shadow copy of the filter state: registers, line store, window, position
	bit [CFG_W-1:0]  cfg_width  = WIDTH_RST;
	bit [CFG_W-1:0]  cfg_height = HEIGHT_RST;
	bit [WORD_W-1:0] line_mem [MAX_WIDTH];
	bit [PIX_W-1:0]  win [TAPS][TAPS];
	int              col_pos = 0;
	int              row_pos = 0;

	// stimulus knobs shared between the test tasks and the sink
	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	int hold_len     = 0;
	// clamped frame size currently programmed
	int frame_w      = WIDTH_RST;
	int frame_h      = HEIGHT_RST;

	box_filter_5x5_mean_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel         (pixel),
		.start_of_frame(start_of_frame),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.mean_value    (mean_value),
		.out_col       (out_col),
		.out_row       (out_row),
		.last_of_frame (last_of_frame)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// out-of-range sizes are pulled into 5..hi before use
	function automatic int clamp_dim(input int v, input int hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// advance the shadow filter by one pixel beat, queue a mean if one is due
	task automatic filter_pixel(input logic [PIX_W-1:0] px, input logic sof);
		int w, h, g, c, r, sum, i, j;
		bit [WORD_W-1:0] word;
		mean_beat_t beat;
		w = clamp_dim(cfg_width, MAX_WIDTH);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		// trailing columns beyond the last full group of 16 are trimmed
		g = GROUP * ((w - (TAPS - 1)) / GROUP);
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		word = line_mem[c % MAX_WIDTH];
		// slide the window left, newest column comes from the line store
		for (i = 0; i < TAPS; i++)
			for (j = 0; j < TAPS - 1; j++)
				win[i][j] = win[i][j + 1];
		for (i = 0; i < TAPS - 1; i++)
			win[i][TAPS - 1] = word[i * PIX_W +: PIX_W];
		win[TAPS - 1][TAPS - 1] = px;
		// oldest row sits in the low byte, newest pixel enters at the top
		line_mem[c % MAX_WIDTH] = {px, word[WORD_W - 1:PIX_W]};
		if (r >= TAPS - 1 && r < h && c >= TAPS - 1 && c < g + TAPS - 1) begin
			sum = 0;
			for (i = 0; i < TAPS; i++)
				for (j = 0; j < TAPS; j++)
					sum += win[i][j];
			beat.mean = PIX_W'(sum / (TAPS * TAPS));
			beat.col  = POS_W'(c - EDGE);
			beat.row  = POS_W'(r - EDGE);
			beat.last = (c == g + TAPS - 2) && (r == h - 1);
			pending_means.push_back(beat);
		end
		// positions past a shrunken frame simply wrap
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	// one process watches every handshake: register writes, result beats, pixel beats
	always @(posedge clk) begin : scoreboard
		mean_beat_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_FRAME_WIDTH)
					cfg_width = pwdata[CFG_W - 1:0];
				else if (paddr == ADDR_FRAME_HEIGHT)
					cfg_height = pwdata[CFG_W - 1:0];
			end
			// results first, so a beat is never matched against its own pixel
			if (result_valid && result_ready) begin
				if (pending_means.size() == 0) begin
					error_count++;
					$error("mean_value: expected no beat, actual %0d at col %0d row %0d",
						mean_value, out_col, out_row);
				end else begin
					want = pending_means.pop_front();
					check_field("mean_value", POS_W'(want.mean), POS_W'(mean_value));
					check_field("out_col", want.col, out_col);
					check_field("out_row", want.row, out_row);
					check_field("last_of_frame", POS_W'(want.last), POS_W'(last_of_frame));
				end
			end
			if (pixel_valid && pixel_ready)
				filter_pixel(pixel, start_of_frame);
		end
	end

	// watchdog: too long without any accepted beat or register access
	always @(posedge clk) begin
		if (!arst_n || psel || (pixel_valid && pixel_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$error("no beat accepted for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_means.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result sink: ready stretches, random stall bursts and the long hold-off
	initial begin : result_sink
		int n;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				result_ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 18);
				result_ready <= 1'b0;
			end else begin
				n = $urandom_range(1, 24);
				result_ready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	// drive pixel beats; start_of_frame on the first one if sof_first is set, optional stray restarts
	task automatic send_pixels(input int count, input logic sof_first, input pix_mode_t mode,
			input bit restarts);
		int k;
		logic [PIX_W-1:0] px;
		logic sof;
		for (k = 0; k < count; k++) begin
			case (mode)
				PIX_WHITE: px = {PIX_W{1'b1}};
				PIX_EXTREME: px = $urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
				default: px = PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
			endcase
			sof = (k == 0) ? sof_first : (restarts && $urandom_range(0, 149) == 0);
			if (src_idle_on && $urandom_range(0, 7) == 0) begin
				pixel_valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			pixel_valid    <= 1'b1;
			pixel          <= px;
			start_of_frame <= sof;
			@(posedge clk);
			while (!pixel_ready) @(posedge clk);
		end
	endtask

	// drop valid, wait for every expected mean, then let the pipeline empty
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup cycle then access cycle; upper data bits are random junk
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input int val);
		logic [DATA_W-1:0] data;
		data = $urandom();
		data[CFG_W - 1:0] = val[CFG_W - 1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// setup cycle then access cycle, data taken at the access edge
	task automatic read_reg(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		val = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame_size(input int w, input int h);
		wait_idle();
		write_reg(ADDR_FRAME_WIDTH, w);
		write_reg(ADDR_FRAME_HEIGHT, h);
		frame_w = clamp_dim(w[CFG_W - 1:0], MAX_WIDTH);
		frame_h = clamp_dim(h[CFG_W - 1:0], MAX_HEIGHT);
	endtask

	// registers come out of reset as 640x480
	task automatic test_reset_size();
		logic [DATA_W-1:0] val;
		read_reg(ADDR_FRAME_WIDTH, val);
		if (val !== DATA_W'(WIDTH_RST)) begin
			error_count++;
			$error("frame_width: expected %0d, actual %0d", WIDTH_RST, val);
		end
		read_reg(ADDR_FRAME_HEIGHT, val);
		if (val !== DATA_W'(HEIGHT_RST)) begin
			error_count++;
			$error("frame_height: expected %0d, actual %0d", HEIGHT_RST, val);
		end
	endtask

	// smallest frame with results, all white; counters start at zero with no start beat
	task automatic test_saturated_frames();
		set_frame_size(20, 5);
		send_pixels(100, 1'b0, PIX_WHITE, 1'b0);
	endtask

	// clamped sizes give a frame too narrow for any group
	task automatic test_narrow_and_trimmed();
		set_frame_size(3, 2);
		send_pixels(frame_w * frame_h, 1'b1, PIX_RANDOM, 1'b0);
	endtask

	// trimmed trailing columns, then shrink width and height in the middle of a frame
	task automatic test_mid_frame_resize();
		set_frame_size(22, 8);
		// four full rows, then row 4 up to the trimmed column 20
		send_pixels(4 * 22 + 21, 1'b1, PIX_RANDOM, 1'b0);
		set_frame_size(20, 8);
		// column 21 is now past the edge, then row 5 at the new width
		send_pixels(1 + 20, 1'b0, PIX_RANDOM, 1'b0);
		set_frame_size(20, 5);
		// row 6 is past the bottom and wraps to the top
		send_pixels(20, 1'b0, PIX_RANDOM, 1'b0);
	endtask

	// sink holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		set_frame_size(20, 5);
		hold_len = HOLD_CYCLES;
		send_pixels(frame_w * frame_h, 1'b1, PIX_RANDOM, 1'b0);
	endtask

	// mostly well-formed small frames, some resized, restarted or run on without a start
	task automatic test_random_frames();
		int sent;
		bit resized;
		bit no_start;
		pix_mode_t mode;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			resized = ($urandom_range(0, 1) == 1);
			if (resized) begin
				if ($urandom_range(0, 7) == 0)
					set_frame_size($urandom_range(0, 19), $urandom_range(0, 6));
				else
					set_frame_size($urandom_range(20, 24), $urandom_range(0, 5));
			end
			// a new size always begins with a start beat
			no_start = !resized && ($urandom_range(0, 5) == 0);
			mode = ($urandom_range(0, 3) == 0) ? PIX_EXTREME : PIX_RANDOM;
			send_pixels(frame_w * frame_h, !no_start, mode, $urandom_range(0, 5) == 0);
			sent += frame_w * frame_h;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		pixel_valid    = 1'b0;
		pixel          = '0;
		start_of_frame = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_saturated_frames();
		test_narrow_and_trimmed();
		test_mid_frame_resize();
		test_random_frames();

		// last part runs at full rate on both sides, apart from the hold-off
		wait_idle();
		test_backpressure();
		wait_idle();

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
